>>> hw/rtl/hbs_pkg.sv
// Shared types and constants for the HDLC transmit bit stuffer.
`default_nettype none

package hbs_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam logic [2:0] RUN_LIMIT = 3'd5;
    localparam logic [2:0] LAST_IDX = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       raw_byte;
    } hbs_item_t;

    typedef struct packed {
        logic line_bit;
        logic stuffed_bit;
        logic last_bit;
    } hbs_sym_t;

    typedef struct packed {
        logic       busy;
        logic [2:0] ones_run;
    } hbs_back_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/hbs_front.sv
// Input side: accepts bytes and holds them in a short queue for the serialiser.
`default_nettype none

module hbs_front
    import hbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    input  wire logic [7:0]                          data_byte,
    input  wire logic                                raw_byte,
    output logic                                     full,
    output logic                                     head_valid,
    output hbs_item_t                                head,
    input  wire logic                                take,
    output logic [$clog2(QUEUE_DEPTH + 1) - 1:0]     count
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W - 1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W - 1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    hbs_item_t slot_reg [QUEUE_DEPTH];
    logic [PTR_W - 1:0] wr_ptr_reg;
    logic [PTR_W - 1:0] wr_ptr_next;
    logic [PTR_W - 1:0] rd_ptr_reg;
    logic [PTR_W - 1:0] rd_ptr_next;
    logic [CNT_W - 1:0] count_reg;
    logic [CNT_W - 1:0] count_next;
    logic               do_push;
    logic               do_take;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_push    = push && !full;
    assign do_take    = take && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_take)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_take)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= '{data_byte: data_byte, raw_byte: raw_byte};
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/hbs_back.sv
// Serialiser: stuffs, NRZI codes one line bit per cycle to a free output register.
`default_nettype none

module hbs_back
    import hbs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       nrzi_enable,
    input  wire logic       head_valid,
    input  wire hbs_item_t  head,
    output logic            take,
    input  wire logic       pop,
    output logic            empty,
    output hbs_sym_t        sym,
    output hbs_back_status_t status
);

    hbs_item_t  item_reg;
    hbs_item_t  item_next;
    logic       busy_reg;
    logic       busy_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       stuff_reg;
    logic       stuff_next;
    logic [2:0] run_reg;
    logic [2:0] run_next;
    logic       level_reg;
    logic       level_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    hbs_sym_t   out_reg;
    hbs_sym_t   out_next;

    logic       slot_free;
    logic       adv;
    logic       cur_bit;
    logic [2:0] run_inc;
    logic       hit;
    logic       last_now;
    logic       load_ok;

    assign slot_free = !out_valid_reg || pop;
    assign adv       = busy_reg && slot_free;
    assign cur_bit   = stuff_reg ? 1'b0 : item_reg.data_byte[idx_reg];
    assign run_inc   = run_reg + 3'd1;
    assign hit       = !stuff_reg && !item_reg.raw_byte && cur_bit && (run_inc >= RUN_LIMIT);
    assign last_now  = (idx_reg == LAST_IDX) && !hit;
    assign load_ok   = !busy_reg || (adv && last_now);
    assign take      = head_valid && load_ok;

    assign empty  = !out_valid_reg;
    assign sym    = out_reg;
    assign status = '{busy: busy_reg, ones_run: run_reg};

    always_comb
    begin
        item_next      = item_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        stuff_next     = stuff_reg;
        run_next       = run_reg;
        level_next     = level_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (adv)
        begin
            if (nrzi_enable && !cur_bit)
            begin
                level_next = !level_reg;
            end
            out_next.line_bit    = nrzi_enable ? level_next : cur_bit;
            out_next.stuffed_bit = stuff_reg;
            out_next.last_bit    = last_now;

            if (stuff_reg)
            begin
                stuff_next = 1'b0;
                run_next   = '0;
                idx_next   = idx_reg + 3'd1;
            end
            else if (hit)
            begin
                stuff_next = 1'b1;
                run_next   = '0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
                if (item_reg.raw_byte || !cur_bit)
                begin
                    run_next = '0;
                end
                else
                begin
                    run_next = run_inc;
                end
            end
        end

        if (slot_free)
        begin
            out_valid_next = adv;
        end

        if (load_ok)
        begin
            busy_next  = head_valid;
            item_next  = head;
            idx_next   = '0;
            stuff_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            stuff_reg     <= 1'b0;
            run_reg       <= '0;
            level_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            stuff_reg     <= stuff_next;
            run_reg       <= run_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/hdlc_tx_bit_stuff_nrzi.sv
// HDLC transmit bit stuffer with NRZI line coding, top level.
//
// Input queue: push a byte with data_byte and raw_byte while full is low.
// raw_byte high sends the byte unstuffed (flag or preamble) and clears the
// ones run; otherwise a zero follows every run of five ones, counted across
// bytes. Bits leave least significant bit first.
// Result queue: while empty is low, line_bit, stuffed_bit and last_bit hold
// the oldest line bit; pop takes it. last_bit marks the final bit of a byte.
// Each byte gives 8 to 10 line bits at one bit per cycle unless the receiver
// stalls; the first bit of a byte pushed into an idle block passes the input
// queue, the serialiser's byte register and the output register on its way
// to the result ports. Bytes queue ahead of the serialiser, so a new byte is
// taken while the current one is shifted. A stalled receiver holds the output
// register and the serialiser; the input queue fills and then raises full.
// Configuration: cfg_data bit 0 is nrzi_enable, written when cfg_valid is
// high (cfg_ready is always high); write it only while the block is idle.
// Reset clears the queues, the ones run and the line level, and sets
// nrzi_enable.
`default_nettype none

module hdlc_tx_bit_stuff_nrzi
    import hbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] data_byte,
    input  wire logic       raw_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic            line_bit,
    output logic            stuffed_bit,
    output logic            last_bit,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic               nrzi_enable_reg;
    logic               head_valid;
    hbs_item_t          head;
    logic               take;
    logic [CNT_W - 1:0] count;
    hbs_sym_t           sym;
    hbs_back_status_t   status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nrzi_enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            nrzi_enable_reg <= cfg_data;
        end
    end

    hbs_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .data_byte (data_byte),
        .raw_byte  (raw_byte),
        .full      (full),
        .head_valid(head_valid),
        .head      (head),
        .take      (take),
        .count     (count)
    );

    hbs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .nrzi_enable(nrzi_enable_reg),
        .head_valid (head_valid),
        .head       (head),
        .take       (take),
        .pop        (pop),
        .empty      (empty),
        .sym        (sym),
        .status     (status)
    );

    assign line_bit    = sym.line_bit;
    assign stuffed_bit = sym.stuffed_bit;
    assign last_bit    = sym.last_bit;

    a_run_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        status.ones_run < RUN_LIMIT)
        else $error("ones run reached the stuffing limit");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(QUEUE_DEPTH))
        else $error("input queue overfilled");

    a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !take) |=> (count == $past(count) + 1'b1))
        else $error("input queue count missed a push");

    a_take_needs_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (take && status.busy) |-> (empty || pop))
        else $error("serialiser advanced into a stalled output");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable({line_bit, stuffed_bit, last_bit})))
        else $error("waiting line bit changed before it was taken");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the HDLC transmit bit stuffer with NRZI coding.
`default_nettype none

module testbench;
    import hbs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] data_byte = 8'h00;
    logic       raw_byte = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic       line_bit;
    logic       stuffed_bit;
    logic       last_bit;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;

    hbs_item_t  pending_bytes[$];
    hbs_sym_t   expected_bits[$];

    logic       nrzi_on = 1'b1;
    logic [2:0] run_ones = 3'd0;
    logic       line_lvl = 1'b0;

    bit         steady = 1'b0;
    int         send_gap = 0;
    int         take_gap = 0;
    int         mismatches = 0;
    int         cycles = 0;

    hdlc_tx_bit_stuff_nrzi i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .raw_byte    (raw_byte),
        .empty       (empty),
        .pop         (pop),
        .line_bit    (line_bit),
        .stuffed_bit (stuffed_bit),
        .last_bit    (last_bit),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void stuff_byte(input hbs_item_t it);
        logic [1:0] seq[$];
        hbs_sym_t   sym;
        int         k;
        seq = {};
        for (k = 0; k < 8; k++)
        begin
            seq.push_back({it.data_byte[k], 1'b0});
            if (it.raw_byte)
            begin
                run_ones = 3'd0;
            end
            else if (it.data_byte[k])
            begin
                run_ones = run_ones + 3'd1;
                if (run_ones >= RUN_LIMIT)
                begin
                    seq.push_back(2'b01);
                    run_ones = 3'd0;
                end
            end
            else
            begin
                run_ones = 3'd0;
            end
        end
        for (k = 0; k < seq.size(); k++)
        begin
            sym.line_bit = seq[k][1];
            if (nrzi_on)
            begin
                if (!seq[k][1])
                begin
                    line_lvl = ~line_lvl;
                end
                sym.line_bit = line_lvl;
            end
            sym.stuffed_bit = seq[k][0];
            sym.last_bit = (k == seq.size() - 1);
            expected_bits.push_back(sym);
        end
    endfunction

    function automatic void queue_byte(input logic [7:0] value, input logic raw);
        hbs_item_t it;
        it.data_byte = value;
        it.raw_byte = raw;
        pending_bytes.push_back(it);
    endfunction

    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 5))
            0: return 8'hFF;
            1: return 8'($urandom | $urandom);
            2: return 8'($urandom & $urandom);
            3: return 8'($urandom | $urandom | $urandom);
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly flag-framed data with random content; some noise and broken frames.
    function automatic void queue_random(input int count);
        int queued;
        int k;
        int len;
        queued = 0;
        while (queued < count)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    queue_byte(8'($urandom), 1'b1);
                    queued++;
                end
                1:
                begin
                    len = $urandom_range(1, 4);
                    for (k = 0; k < len; k++)
                    begin
                        queue_byte(pick_data(), 1'b0);
                    end
                    queued += len;
                end
                default:
                begin
                    len = $urandom_range(1, 2);
                    for (k = 0; k < len; k++)
                    begin
                        queue_byte(8'h7E, 1'b1);
                    end
                    queued += len;
                    len = $urandom_range(1, 8);
                    for (k = 0; k < len; k++)
                    begin
                        queue_byte(pick_data(), 1'b0);
                    end
                    queue_byte(8'h7E, 1'b1);
                    queued += len + 1;
                end
            endcase
        end
    endfunction

    function automatic void queue_directed();
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h7E, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'h7E, 1'b0);
        queue_byte(8'h1F, 1'b0);
        queue_byte(8'hF8, 1'b0);
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hE0, 1'b0);
        queue_byte(8'h7E, 1'b1);
        queue_byte(8'h0F, 1'b0);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hBF, 1'b0);
    endfunction

    task automatic drain();
        while (pending_bytes.size() != 0 || expected_bits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_nrzi(input logic value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        nrzi_on = value;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                stuff_byte(pending_bytes.pop_front());
            end
            if (send_gap != 0)
            begin
                send_gap--;
                push <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 11) == 0)
            begin
                send_gap = $urandom_range(1, 14) - 1;
                push <= 1'b0;
            end
            else if (pending_bytes.size() != 0)
            begin
                push <= 1'b1;
                data_byte <= pending_bytes[0].data_byte;
                raw_byte <= pending_bytes[0].raw_byte;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        hbs_sym_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_bits.size() == 0)
                begin
                    $error("line bit with none expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_bits.pop_front();
                    if (line_bit !== want.line_bit)
                    begin
                        $error("line_bit: expected %0b, got %0b", want.line_bit, line_bit);
                        mismatches++;
                    end
                    if (stuffed_bit !== want.stuffed_bit)
                    begin
                        $error("stuffed_bit: expected %0b, got %0b",
                               want.stuffed_bit, stuffed_bit);
                        mismatches++;
                    end
                    if (last_bit !== want.last_bit)
                    begin
                        $error("last_bit: expected %0b, got %0b", want.last_bit, last_bit);
                        mismatches++;
                    end
                end
            end
            if (take_gap != 0)
            begin
                take_gap--;
                pop <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 9) == 0)
            begin
                take_gap = $urandom_range(1, 14) - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        queue_directed();
        drain();
        write_nrzi(1'b0);
        queue_directed();
        drain();
        write_nrzi(1'b1);
        queue_random(120);
        drain();
        write_nrzi(1'b0);
        queue_random(120);
        drain();
        write_nrzi(1'b1);
        queue_random(60);
        drain();
        steady = 1'b1;
        queue_random(80);
        drain();
        repeat (20) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
